// File: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the list store blocks.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge out of reset.
`define BLS_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// Consequent that must hold in the cycle after the antecedent.
`define BLS_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/bls_pkg.sv
// ----------------------------------------------------------------------------
// List store package
// Field widths, operation and status codes, and controller/datapath links.
// ----------------------------------------------------------------------------
package bls_pkg;

  localparam int unsigned DEF_CAPACITY = 1024;

  localparam int unsigned OP_W   = 3;
  localparam int unsigned VAL_W  = 64;
  localparam int unsigned POS_W  = 10;
  localparam int unsigned STAT_W = 2;
  localparam int unsigned IDX_W  = 10;
  localparam int unsigned LEN_W  = 11;

  typedef enum logic [OP_W-1:0] {
    OP_APPEND = 3'd0,
    OP_REMOVE = 3'd1,
    OP_READ   = 3'd2,
    OP_FIND   = 3'd3,
    OP_FILL   = 3'd4,
    OP_CLEAR  = 3'd5
  } op_e;

  typedef enum logic [STAT_W-1:0] {
    ST_OK       = 2'd0,
    ST_RANGE    = 2'd1,
    ST_FULL     = 2'd2,
    ST_NOTFOUND = 2'd3
  } status_e;

  typedef enum logic [1:0] {WR_NONE, WR_APPEND, WR_SHIFT, WR_FILL} wr_sel_e;
  typedef enum logic [1:0] {PTR_HOLD, PTR_POS, PTR_POS1, PTR_INC} ptr_op_e;
  typedef enum logic [1:0] {FC_HOLD, FC_INC, FC_DEC, FC_CLR} fc_op_e;
  typedef enum logic [1:0] {RES_NONE, RES_DATA, RES_INDEX} res_sel_e;
  typedef enum logic {RD_POS, RD_PTR} rd_src_e;

  // Controller to datapath
  typedef struct packed {
    logic     in_ready;
    logic     capture;
    logic     rd_en;
    rd_src_e  rd_src;
    wr_sel_e  wr_sel;
    ptr_op_e  ptr_op;
    fc_op_e   fc_op;
    logic     res_load;
    status_e  res_status;
    res_sel_e res_sel;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic            in_valid;
    logic [OP_W-1:0] op;
    logic            full;
    logic            pos_ge_len;
    logic            pos_gt_end;
    logic            scan_more;
    logic            rd_pend;
    logic            rd_hit;
    logic            fill_last;
    logic            out_free;
  } stat_t;

endpackage

// File: rtl/bls_if.sv
// ----------------------------------------------------------------------------
// List store channels
// Request and result channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface bls_req_if;
  import bls_pkg::*;

  logic             valid;
  logic             ready;
  logic [OP_W-1:0]  op;
  logic [VAL_W-1:0] value;
  logic [POS_W-1:0] position;
  logic [POS_W-1:0] stop_position;

  modport source (output valid, output op, output value, output position,
                  output stop_position, input ready);
  modport sink   (input valid, input op, input value, input position,
                  input stop_position, output ready);
endinterface

interface bls_rsp_if;
  import bls_pkg::*;

  logic              valid;
  logic              ready;
  logic [STAT_W-1:0] status;
  logic [VAL_W-1:0]  data;
  logic [IDX_W-1:0]  index;
  logic [LEN_W-1:0]  length;

  modport source (output valid, output status, output data, output index,
                  output length, input ready);
  modport sink   (input valid, input status, input data, input index,
                  input length, output ready);
endinterface

// File: rtl/bls_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module bls_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;
endmodule

// File: rtl/bls_ctrl.sv
// ----------------------------------------------------------------------------
// List store controller
// Sequences each request: decode, memory walk, and result hand-off.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module bls_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  bls_pkg::stat_t stat_i,
  output bls_pkg::cmd_t  cmd_o
);
  import bls_pkg::*;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_EXEC   = 3'd1;
  localparam logic [2:0] S_RDWAIT = 3'd2;
  localparam logic [2:0] S_SHIFT  = 3'd3;
  localparam logic [2:0] S_FIND   = 3'd4;
  localparam logic [2:0] S_FILL   = 3'd5;
  localparam logic [2:0] S_HOLD   = 3'd6;

  logic [2:0] state_q, state_d;
  status_e    hold_st_q, hold_st_d;
  res_sel_e   hold_sel_q, hold_sel_d;

  logic       fin;
  status_e    fin_st;
  res_sel_e   fin_sel;

  always_comb begin
    cmd_o            = '0;
    cmd_o.rd_src     = RD_POS;
    cmd_o.wr_sel     = WR_NONE;
    cmd_o.ptr_op     = PTR_HOLD;
    cmd_o.fc_op      = FC_HOLD;
    cmd_o.res_status = ST_OK;
    cmd_o.res_sel    = RES_NONE;
    state_d          = state_q;
    hold_st_d        = hold_st_q;
    hold_sel_d       = hold_sel_q;
    fin              = 1'b0;
    fin_st           = ST_OK;
    fin_sel          = RES_NONE;

    unique case (state_q)
      S_IDLE: begin
        cmd_o.in_ready = 1'b1;
        if (stat_i.in_valid) begin
          cmd_o.capture = 1'b1;
          state_d       = S_EXEC;
        end
      end

      S_EXEC: begin
        unique case (stat_i.op)
          OP_APPEND: begin
            fin = 1'b1;
            if (stat_i.full) begin
              fin_st = ST_FULL;
            end else begin
              cmd_o.wr_sel = WR_APPEND;
              cmd_o.fc_op  = FC_INC;
            end
          end
          OP_REMOVE: begin
            if (stat_i.pos_ge_len) begin
              fin    = 1'b1;
              fin_st = ST_RANGE;
            end else begin
              cmd_o.ptr_op = PTR_POS1;
              state_d      = S_SHIFT;
            end
          end
          OP_READ: begin
            if (stat_i.pos_ge_len) begin
              fin    = 1'b1;
              fin_st = ST_RANGE;
            end else begin
              cmd_o.rd_en  = 1'b1;
              cmd_o.rd_src = RD_POS;
              state_d      = S_RDWAIT;
            end
          end
          OP_FIND: begin
            if (stat_i.pos_ge_len) begin
              fin    = 1'b1;
              fin_st = ST_NOTFOUND;
            end else begin
              cmd_o.ptr_op = PTR_POS;
              state_d      = S_FIND;
            end
          end
          OP_FILL: begin
            if (stat_i.pos_ge_len) begin
              fin    = 1'b1;
              fin_st = ST_RANGE;
            end else if (stat_i.pos_gt_end) begin
              fin = 1'b1;
            end else begin
              cmd_o.ptr_op = PTR_POS;
              state_d      = S_FILL;
            end
          end
          OP_CLEAR: begin
            cmd_o.fc_op = FC_CLR;
            fin         = 1'b1;
          end
          default: begin
            fin = 1'b1;
          end
        endcase
      end

      S_RDWAIT: begin
        fin     = 1'b1;
        fin_sel = RES_DATA;
      end

      // Read the next word while writing the previous one a slot lower.
      S_SHIFT: begin
        if (stat_i.rd_pend) begin
          cmd_o.wr_sel = WR_SHIFT;
        end
        if (stat_i.scan_more) begin
          cmd_o.rd_en  = 1'b1;
          cmd_o.rd_src = RD_PTR;
          cmd_o.ptr_op = PTR_INC;
        end else begin
          cmd_o.fc_op = FC_DEC;
          fin         = 1'b1;
        end
      end

      // Compare the word read last cycle; stop on the first match.
      S_FIND: begin
        if (stat_i.rd_hit) begin
          fin     = 1'b1;
          fin_sel = RES_INDEX;
        end else if (stat_i.scan_more) begin
          cmd_o.rd_en  = 1'b1;
          cmd_o.rd_src = RD_PTR;
          cmd_o.ptr_op = PTR_INC;
        end else begin
          fin    = 1'b1;
          fin_st = ST_NOTFOUND;
        end
      end

      S_FILL: begin
        cmd_o.wr_sel = WR_FILL;
        if (stat_i.fill_last) begin
          fin = 1'b1;
        end else begin
          cmd_o.ptr_op = PTR_INC;
        end
      end

      // Hold the finished result until the output register frees.
      S_HOLD: begin
        if (stat_i.out_free) begin
          cmd_o.res_load   = 1'b1;
          cmd_o.res_status = hold_st_q;
          cmd_o.res_sel    = hold_sel_q;
          state_d          = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase

    if (fin) begin
      if (stat_i.out_free) begin
        cmd_o.res_load   = 1'b1;
        cmd_o.res_status = fin_st;
        cmd_o.res_sel    = fin_sel;
        state_d          = S_IDLE;
      end else begin
        hold_st_d  = fin_st;
        hold_sel_d = fin_sel;
        state_d    = S_HOLD;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      hold_st_q  <= ST_OK;
      hold_sel_q <= RES_NONE;
    end else begin
      state_q    <= state_d;
      hold_st_q  <= hold_st_d;
      hold_sel_q <= hold_sel_d;
    end
  end

  `BLS_ASSERT(a_state_legal, clk_i, rst_ni, state_q <= S_HOLD, "illegal controller state")
  `BLS_ASSERT(a_load_free, clk_i, rst_ni, !cmd_o.res_load || stat_i.out_free, "result reg busy")
  `BLS_ASSERT(a_ready_idle, clk_i, rst_ni, cmd_o.in_ready == (state_q == S_IDLE), "ready not idle")
  `BLS_ASSERT_NEXT(a_capture_exec, clk_i, rst_ni, cmd_o.capture, state_q == S_EXEC, "no execute")

endmodule

// File: rtl/bls_dp.sv
// ----------------------------------------------------------------------------
// List store datapath
// Request capture, fill count, word memory, scan pointer and result register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module bls_dp #(
  parameter int unsigned CAPACITY = bls_pkg::DEF_CAPACITY
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  bls_pkg::cmd_t  cmd_i,
  output bls_pkg::stat_t stat_o,
  bls_req_if.sink        req_i,
  bls_rsp_if.source      rsp_o
);
  import bls_pkg::*;

  localparam int unsigned AW   = $clog2(CAPACITY);
  localparam int unsigned CW   = $clog2(CAPACITY + 1);
  localparam int unsigned CMPW = (CW > POS_W) ? CW : POS_W;

  // Captured request
  logic [OP_W-1:0]  op_q;
  logic [VAL_W-1:0] val_q;
  logic [POS_W-1:0] pos_q;
  logic [POS_W-1:0] endp_q;

  logic [CW-1:0]    fc_q, fc_d;
  logic [CW-1:0]    ptr_q, ptr_d;
  logic             rd_pend_q;
  logic [AW-1:0]    rd_addr_q;

  logic             we;
  logic [AW-1:0]    waddr;
  logic [VAL_W-1:0] wdata;
  logic [AW-1:0]    raddr;
  logic [VAL_W-1:0] rdata;

  logic              out_valid_q;
  logic [STAT_W-1:0] out_status_q;
  logic [VAL_W-1:0]  out_data_q;
  logic [IDX_W-1:0]  out_index_q;
  logic [LEN_W-1:0]  out_length_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q   <= req_i.op;
      val_q  <= req_i.value;
      pos_q  <= req_i.position;
      endp_q <= req_i.stop_position;
    end
  end

  always_comb begin
    unique case (cmd_i.fc_op)
      FC_INC:  fc_d = fc_q + CW'(1);
      FC_DEC:  fc_d = fc_q - CW'(1);
      FC_CLR:  fc_d = '0;
      default: fc_d = fc_q;
    endcase
  end

  always_comb begin
    unique case (cmd_i.ptr_op)
      PTR_POS:  ptr_d = CW'(pos_q);
      PTR_POS1: ptr_d = CW'(pos_q) + CW'(1);
      PTR_INC:  ptr_d = ptr_q + CW'(1);
      default:  ptr_d = ptr_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fc_q      <= '0;
      ptr_q     <= '0;
      rd_pend_q <= 1'b0;
    end else begin
      fc_q      <= fc_d;
      ptr_q     <= ptr_d;
      rd_pend_q <= cmd_i.rd_en;
    end
  end

  assign raddr = (cmd_i.rd_src == RD_PTR) ? ptr_q[AW-1:0] : AW'(pos_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.rd_en) begin
      rd_addr_q <= raddr;
    end
  end

  // Write port select
  always_comb begin
    we    = 1'b1;
    waddr = fc_q[AW-1:0];
    wdata = val_q;
    unique case (cmd_i.wr_sel)
      WR_APPEND: begin
        waddr = fc_q[AW-1:0];
        wdata = val_q;
      end
      WR_SHIFT: begin
        waddr = rd_addr_q - AW'(1);
        wdata = rdata;
      end
      WR_FILL: begin
        waddr = ptr_q[AW-1:0];
        wdata = val_q;
      end
      default: begin
        we = 1'b0;
      end
    endcase
  end

  bls_ram #(
    .WIDTH (VAL_W),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (cmd_i.rd_en),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.res_load) begin
      out_valid_q <= 1'b1;
    end else if (rsp_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.res_load) begin
      out_status_q <= cmd_i.res_status;
      out_data_q   <= (cmd_i.res_sel == RES_DATA) ? rdata : '0;
      out_index_q  <= (cmd_i.res_sel == RES_INDEX) ? IDX_W'(rd_addr_q) : '0;
      out_length_q <= LEN_W'(fc_d);
    end
  end

  assign req_i.ready  = cmd_i.in_ready;
  assign rsp_o.valid  = out_valid_q;
  assign rsp_o.status = out_status_q;
  assign rsp_o.data   = out_data_q;
  assign rsp_o.index  = out_index_q;
  assign rsp_o.length = out_length_q;

  assign stat_o.in_valid   = req_i.valid;
  assign stat_o.op         = op_q;
  assign stat_o.full       = (fc_q == CW'(CAPACITY));
  assign stat_o.pos_ge_len = (CMPW'(pos_q) >= CMPW'(fc_q));
  assign stat_o.pos_gt_end = (pos_q > endp_q);
  assign stat_o.scan_more  = (ptr_q < fc_q);
  assign stat_o.rd_pend    = rd_pend_q;
  assign stat_o.rd_hit     = rd_pend_q && (rdata == val_q);
  assign stat_o.fill_last  = (CMPW'(ptr_q) >= CMPW'(endp_q)) ||
                             ((ptr_q + CW'(1)) >= fc_q);
  assign stat_o.out_free   = !out_valid_q || rsp_o.ready;

  `BLS_ASSERT(a_fc_bound, clk_i, rst_ni, fc_q <= CW'(CAPACITY), "fill count above capacity")
  `BLS_ASSERT(a_inc_not_full, clk_i, rst_ni, (cmd_i.fc_op == FC_INC) |-> !stat_o.full, "append past capacity")
  `BLS_ASSERT(a_shift_pend, clk_i, rst_ni, (cmd_i.wr_sel == WR_SHIFT) |-> rd_pend_q, "shift write without read data")

endmodule

// File: rtl/bounded_list_store_engine.sv
// ----------------------------------------------------------------------------
// Bounded list store engine
// Fixed-capacity list of 64-bit words with append, remove, read, find, fill
// and clear, built as a controller and a datapath around one word memory.
// ----------------------------------------------------------------------------
//
//  channel | side   | payload
//  --------+--------+---------------------------------------------
//  req_i   | sink   | op, value, position, stop_position
//  rsp_o   | source | status, data, index, length
//
// Remove, fill and find walk the list word by word through the single read
// port and single write port of the memory; append, clear, read, out-of-range
// and unused ops finish without a walk.
// Reset clears the control registers; the memory takes no clearing pass.
// A finished result waits in the output register; a new request is taken
// as soon as its predecessor's result has been loaded there.
module bounded_list_store_engine #(
  parameter int unsigned CAPACITY = bls_pkg::DEF_CAPACITY
) (
  input logic       clk_i,
  input logic       rst_ni,
  bls_req_if.sink   req_i,
  bls_rsp_if.source rsp_o
);
  import bls_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  // Sequence the requests
  bls_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .stat_i (stat),
    .cmd_o  (cmd)
  );

  // Hold the list and the result register
  bls_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd),
    .stat_o (stat),
    .req_i  (req_i),
    .rsp_o  (rsp_o)
  );

endmodule
